FILE: sv/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

  localparam int OP_W = 3;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_FRAME  = 3'd0,
    REG_END_FRAME    = 3'd1,
    REG_PING_PONG    = 3'd2,
    REG_LOOP_ENABLE  = 3'd3,
    REG_FRAME_PERIOD = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: sv/sfs_in_if.sv
`default_nettype none

interface sfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::OP_W-1:0]      op;
  logic [sfs_pkg::ELAPSED_W-1:0] elapsed;

  modport source (output valid, output op, output elapsed, input ready);
  modport sink (input valid, input op, input elapsed, output ready);
endinterface

`default_nettype wire

FILE: sv/sfs_out_if.sv
`default_nettype none

interface sfs_out_if #(
  parameter int FRAME_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] frame;
  logic [FRAME_BITS:0]   position;
  logic                  playing;
  logic                  finished;

  modport source (output valid, output frame, output position, output playing,
                  output finished, input ready);
  modport sink (input valid, input frame, input position, input playing,
                input finished, output ready);
endinterface

`default_nettype wire

FILE: sv/sfs_geom.sv
`default_nettype none

// Sequence geometry: length of the play sequence and the frame shown at a position.
module sfs_geom #(
  parameter int FRAME_BITS = 10
) (
  input  wire logic [FRAME_BITS-1:0] start_frame,
  input  wire logic [FRAME_BITS-1:0] end_frame,
  input  wire logic                  ping_pong,
  input  wire logic                  loop_enable,
  input  wire logic [FRAME_BITS:0]   pos,
  output logic      [FRAME_BITS:0]   seq_len,
  output logic      [FRAME_BITS-1:0] frame
);
  localparam int F = FRAME_BITS;
  localparam int P = FRAME_BITS + 1;

  logic         up;
  logic [F-1:0] span;
  logic [P-1:0] last, two_d;
  logic [P-1:0] pos_c, off_p;
  logic [F-1:0] off;

  always_comb begin
    up = (end_frame >= start_frame);
    span = up ? (end_frame - start_frame) : (start_frame - end_frame);
    if (span == '0) begin
      seq_len = P'(1);
    end else if (!ping_pong) begin
      seq_len = P'(span) + P'(1);
    end else if (loop_enable) begin
      seq_len = {span, 1'b0};
    end else begin
      seq_len = {span, 1'b1};
    end
  end

  always_comb begin
    last = seq_len - P'(1);
    two_d = {span, 1'b0};
    pos_c = (pos >= seq_len) ? last : pos;
    // Past the turn of a ping-pong the offset runs back down.
    off_p = (pos_c <= P'(span)) ? pos_c : (two_d - pos_c);
    off = off_p[F-1:0];
    frame = up ? (start_frame + off) : (start_frame - off);
  end

endmodule

`default_nettype wire

FILE: sv/sprite_frame_sequencer_top.sv
// An accepted input beat passes through the input register, then the state update and
// frame lookup load the result register, from which its result beat is offered.
// Throughput: one item per cycle unless result.ready stalls; each item's add, compare,
// position step and frame lookup end between the two registers; next item follows at once.
// Reset (rst, synchronous, active high) empties both registers, stops playback,
// clears the accumulator and position, and loads the configuration defaults.
`default_nettype none

module sprite_frame_sequencer_top #(
  parameter int FRAME_BITS = 10,
  parameter int TIME_BITS  = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [((TIME_BITS > FRAME_BITS) ? TIME_BITS : FRAME_BITS)-1:0] cfg_data,
  sfs_in_if.sink                                    item,
  sfs_out_if.source                                 result
);
  import sfs_pkg::*;

  localparam int F = FRAME_BITS;
  localparam int P = FRAME_BITS + 1;
  localparam int T = TIME_BITS;
  localparam int A = TIME_BITS + 1;
  localparam int SW = ((A > ELAPSED_W) ? A : ELAPSED_W) + 1;
  localparam logic [A-1:0] ACC_MAX = '1;

  // Configuration registers.
  logic [F-1:0] start_frame, end_frame;
  logic         ping_pong, loop_enable;
  logic [T-1:0] frame_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame <= '0;
      end_frame <= '0;
      ping_pong <= 1'b0;
      loop_enable <= 1'b0;
      frame_period <= T'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_FRAME:  start_frame <= cfg_data[F-1:0];
        REG_END_FRAME:    end_frame <= cfg_data[F-1:0];
        REG_PING_PONG:    ping_pong <= cfg_data[0];
        REG_LOOP_ENABLE:  loop_enable <= cfg_data[0];
        REG_FRAME_PERIOD: frame_period <= cfg_data[T-1:0];
        default: ;
      endcase
    end
  end

  // Handshake between the input register and the result register.
  logic                 s1_v, o_v;
  op_t                  s1_op;
  logic [ELAPSED_W-1:0] s1_elapsed;
  logic                 out_load, s1_move;

  assign out_load = !o_v || result.ready;
  assign s1_move = s1_v && out_load;
  assign item.ready = !s1_v || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (item.ready) begin
      s1_v <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op <= op_t'(item.op);
      s1_elapsed <= item.elapsed;
    end
  end

  // Playback state.
  logic [A-1:0] acc, acc_next;
  logic [P-1:0] pos, pos_next;
  logic         running, running_next, fin_next;
  logic [SW-1:0] acc_sum;
  logic [A-1:0]  acc_sat;
  logic [P-1:0]  seq_len;
  logic [P:0]    pos_inc;

  always_comb begin
    acc_next = acc;
    pos_next = pos;
    running_next = running;
    fin_next = 1'b0;
    acc_sum = SW'(acc) + SW'(s1_elapsed);
    acc_sat = (acc_sum > SW'(ACC_MAX)) ? ACC_MAX : acc_sum[A-1:0];
    pos_inc = {1'b0, pos} + (P+1)'(1);
    case (s1_op)
      OP_TICK: begin
        if (running) begin
          acc_next = acc_sat;
          // At most one advance per tick, however much time has built up.
          if (acc_sat >= A'(frame_period)) begin
            acc_next = acc_sat - A'(frame_period);
            if (pos_inc >= {1'b0, seq_len}) begin
              if (loop_enable) begin
                pos_next = '0;
              end else begin
                pos_next = seq_len - P'(1);
                running_next = 1'b0;
                fin_next = 1'b1;
              end
            end else begin
              pos_next = pos_inc[P-1:0];
            end
          end
        end
      end
      OP_START: begin
        if (!running) begin
          running_next = 1'b1;
          pos_next = '0;
        end
      end
      OP_STOP: begin
        running_next = 1'b0;
        pos_next = '0;
      end
      OP_PAUSE:  running_next = 1'b0;
      OP_RESUME: running_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pos <= '0;
      running <= 1'b0;
    end else if (s1_move) begin
      acc <= acc_next;
      pos <= pos_next;
      running <= running_next;
    end
  end

  logic [F-1:0] frame_c;

  sfs_geom #(
    .FRAME_BITS(FRAME_BITS)
  ) u_geom (
    .start_frame(start_frame),
    .end_frame(end_frame),
    .ping_pong(ping_pong),
    .loop_enable(loop_enable),
    .pos(pos_next),
    .seq_len(seq_len),
    .frame(frame_c)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (out_load) begin
      o_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.frame <= frame_c;
      result.position <= pos_next;
      result.playing <= running_next;
      result.finished <= fin_next;
    end
  end

  assign result.valid = o_v;

endmodule

`default_nettype wire

FILE: sv/sfs_checker.sv
`default_nettype none

module sfs_checker #(
  parameter int FRAME_BITS = 10
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [FRAME_BITS-1:0] out_frame,
  input wire logic [FRAME_BITS:0]   out_position,
  input wire logic                  out_playing,
  input wire logic                  out_finished
);

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A finishing beat always reports playback stopped.
  a_fin_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_finished |-> !out_playing)
    else $error("finished beat still playing");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled finish flag, position and frame must not change; a lost flag means a lost end event.
  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_finished) && $stable(out_position)
      && $stable(out_frame))
    else $error("result payload changed while stalled");

endmodule

bind sprite_frame_sequencer_top sfs_checker #(
  .FRAME_BITS(FRAME_BITS)
) u_sfs_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_frame(result.frame),
  .out_position(result.position),
  .out_playing(result.playing),
  .out_finished(result.finished)
);

`default_nettype wire
